// ----- design/drc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package drc_pkg;

   // Default configuration of the table and of the coordinate width.
   localparam int unsigned DefMaxEntries = 16;
   localparam int unsigned DefCoordBits  = 16;

   // Reset values of the configuration registers.
   localparam logic [4:0]  CapacityReset = 5'd16;
   localparam logic [15:0] SlackReset    = 16'd512;

   // Configuration register indexes.
   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_SLACK    = 1'b1;

   // Command codes of an input item.
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Status codes of a result item.
   localparam logic [2:0] ST_MERGED   = 3'd0;
   localparam logic [2:0] ST_APPENDED = 3'd1;
   localparam logic [2:0] ST_FORCED   = 3'd2;
   localparam logic [2:0] ST_IGNORED  = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;
   localparam logic [2:0] ST_READ_OK  = 3'd5;
   localparam logic [2:0] ST_READ_OOR = 3'd6;

   // Tag of an entry that holds rectangles of different sources.
   localparam logic [15:0] SRC_MIXED = 16'hFFFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDWAIT,
      S_FETCH,
      S_FEED,
      S_WAIT,
      S_DECIDE,
      S_EMIT
   } state_type;

   // Status of the entry evaluator toward the sequencer.
   typedef struct packed {
      logic valid;
      logic merge;
   } eval_flags_type;

endpackage

`default_nettype wire

// ----- design/drc_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none

module drc_eval import drc_pkg::*; #(
   parameter int unsigned COORD_BITS = DefCoordBits
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [4*COORD_BITS+15:0]  entry,
   input  wire logic [4*COORD_BITS+15:0]  rect,
   input  wire logic [15:0]               slack,
   output      eval_flags_type            flags,
   output      logic [2*COORD_BITS+1:0]   cost,
   output      logic [4*COORD_BITS+15:0]  union_box
);

   localparam int unsigned CB = COORD_BITS;
   localparam int unsigned EW = 4 * CB + 16;
   localparam int unsigned DW = CB + 1;
   localparam int unsigned AW = 2 * DW;
   localparam logic signed [CB:0]   ONE1 = 1;
   localparam logic signed [CB+1:0] ONE2 = 1;

   // Width of an inclusive span; the span is never negative here.
   function automatic logic [DW-1:0] span(input logic signed [CB-1:0] lo,
                                          input logic signed [CB-1:0] hi);
      logic signed [CB+1:0] d;
      d = (CB+2)'(hi) - (CB+2)'(lo) + ONE2;
      return d[DW-1:0];
   endfunction

   logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
   logic signed [CB-1:0] ux0, uy0, ux1, uy1;
   logic [15:0]          asrc, bsrc, usrc;
   logic                 touch;

   assign ax0  = entry[EW-1 -: CB];
   assign ay0  = entry[EW-1-CB -: CB];
   assign ax1  = entry[EW-1-2*CB -: CB];
   assign ay1  = entry[EW-1-3*CB -: CB];
   assign asrc = entry[15:0];
   assign bx0  = rect[EW-1 -: CB];
   assign by0  = rect[EW-1-CB -: CB];
   assign bx1  = rect[EW-1-2*CB -: CB];
   assign by1  = rect[EW-1-3*CB -: CB];
   assign bsrc = rect[15:0];

   // Bounding union and the touch or overlap test.
   always_comb begin
      ux0   = (bx0 < ax0) ? bx0 : ax0;
      uy0   = (by0 < ay0) ? by0 : ay0;
      ux1   = (bx1 > ax1) ? bx1 : ax1;
      uy1   = (by1 > ay1) ? by1 : ay1;
      usrc  = (asrc != bsrc) ? SRC_MIXED : asrc;
      touch = ((CB+1)'(ax0) <= (CB+1)'(bx1) + ONE1) &&
              ((CB+1)'(ax1) + ONE1 >= (CB+1)'(bx0)) &&
              ((CB+1)'(ay0) <= (CB+1)'(by1) + ONE1) &&
              ((CB+1)'(ay1) + ONE1 >= (CB+1)'(by0));
   end

   // Stage one: spans of the union and of both rectangles.
   logic          s1_valid_ff, s1_touch_ff;
   logic [EW-1:0] s1_union_ff;
   logic [DW-1:0] s1_uw_ff, s1_uh_ff, s1_aw_ff, s1_ah_ff, s1_bw_ff, s1_bh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_touch_ff <= touch;
      s1_union_ff <= {ux0, uy0, ux1, uy1, usrc};
      s1_uw_ff    <= span(ux0, ux1);
      s1_uh_ff    <= span(uy0, uy1);
      s1_aw_ff    <= span(ax0, ax1);
      s1_ah_ff    <= span(ay0, ay1);
      s1_bw_ff    <= span(bx0, bx1);
      s1_bh_ff    <= span(by0, by1);
   end

   // Stage two: the three exact areas.
   logic          s2_valid_ff, s2_touch_ff;
   logic [EW-1:0] s2_union_ff;
   logic [AW-1:0] s2_au_ff, s2_aa_ff, s2_ab_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_touch_ff <= s1_touch_ff;
      s2_union_ff <= s1_union_ff;
      s2_au_ff    <= s1_uw_ff * s1_uh_ff;
      s2_aa_ff    <= s1_aw_ff * s1_ah_ff;
      s2_ab_ff    <= s1_bw_ff * s1_bh_ff;
   end

   // Merge when the rectangles touch or overlap, or when the union exceeds the separate areas by at most the slack.
   logic [AW+1:0] allowed;
   assign allowed     = (AW+2)'(s2_aa_ff) + (AW+2)'(s2_ab_ff) + (AW+2)'(slack);
   assign flags.valid = s2_valid_ff;
   assign flags.merge = s2_touch_ff || ((AW+2)'(s2_au_ff) <= allowed);
   assign cost        = s2_au_ff - s2_aa_ff;
   assign union_box   = s2_union_ff;

endmodule

`default_nettype wire

// ----- design/dirty_rect_coalescer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Dirty rectangle coalescer.
// Items enter on the req_ channel (valid and stall) and carry a command: add a
// rectangle, clear the table, or read one entry. Every item gives exactly one
// result item on the rsp_ channel with a status, the entry touched and the
// number of valid entries afterwards. The user must write capacity (index 0)
// and merge slack (index 1) on csr_ only while the block is idle; the block
// itself does not enforce this. The block works on one item at a time. Clear,
// ignored adds and an add that appends at an empty table go straight to the
// result register; a read first waits for the registered table memory. Other
// adds scan the table with the entry evaluator, each entry read from the table
// memory passing memory read, span stage, area stage and decision in order;
// a scan stops at the first entry that merges.
// A new item is accepted as soon as the previous one is finished, even while
// its result still waits in the output register; a stalled result holds and
// the next finished result waits behind it.
// Reset empties the table and restores capacity 16 and slack 512; table
// contents are not cleared, the entry count guards every read.
module dirty_rect_coalescer_unit import drc_pkg::*; #(
   parameter int unsigned MAX_ENTRIES = DefMaxEntries,
   parameter int unsigned COORD_BITS  = DefCoordBits
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [1:0]                   req_cmd,
   input  wire logic signed [COORD_BITS-1:0] req_in_x_min,
   input  wire logic signed [COORD_BITS-1:0] req_in_y_min,
   input  wire logic signed [COORD_BITS-1:0] req_in_x_max,
   input  wire logic signed [COORD_BITS-1:0] req_in_y_max,
   input  wire logic signed [15:0]           req_in_source,
   input  wire logic [3:0]                   req_read_slot,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [2:0]                   rsp_status,
   output      logic [3:0]                   rsp_out_slot,
   output      logic signed [COORD_BITS-1:0] rsp_out_x_min,
   output      logic signed [COORD_BITS-1:0] rsp_out_y_min,
   output      logic signed [COORD_BITS-1:0] rsp_out_x_max,
   output      logic signed [COORD_BITS-1:0] rsp_out_y_max,
   output      logic signed [15:0]           rsp_out_source,
   output      logic [4:0]                   rsp_entry_total,
   input  wire logic                         csr_write,
   input  wire logic                         csr_index,
   input  wire logic [15:0]                  csr_data
);

   localparam int unsigned CB   = COORD_BITS;
   localparam int unsigned EW   = 4 * CB + 16;
   localparam int unsigned AW   = 2 * CB + 2;
   localparam int unsigned IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned VW   = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CNTW = (VW > 5) ? VW : 5;
   localparam int unsigned SW   = (IW > 4) ? IW : 4;
   localparam logic [CNTW-1:0] MaxCount = CNTW'(MAX_ENTRIES);

   state_type       state_ff, state_in;
   logic [VW-1:0]   vc_ff, vc_in;
   logic [4:0]      cap_ff;
   logic [15:0]     slack_ff;
   logic [EW-1:0]   rect_ff, rect_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]   best_idx_ff, best_idx_in;
   logic [AW-1:0]   least_grow_ff, least_grow_in;
   logic [EW-1:0]   best_union_ff, best_union_in;
   logic [2:0]      res_status_ff, res_status_in;
   logic [IW-1:0]   res_slot_ff, res_slot_in;
   logic [EW-1:0]   res_box_ff, res_box_in;
   logic            rsp_valid_ff;
   logic [2:0]      rsp_status_ff;
   logic [3:0]      rsp_slot_ff;
   logic [EW-1:0]   rsp_box_ff;
   logic [4:0]      rsp_total_ff;

   // Table memory with one write port and a registered read.
   logic [EW-1:0]   table_mem [MAX_ENTRIES];
   logic [EW-1:0]   rd_data_ff;
   logic [IW-1:0]   rd_addr;
   logic            wr_en;
   logic [IW-1:0]   wr_addr;
   logic [EW-1:0]   wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // Entry evaluator: touch test, union, area growth.
   eval_flags_type  ev_flags;
   logic [AW-1:0]   ev_cost;
   logic [EW-1:0]   ev_union;

   drc_eval #(.COORD_BITS(CB)) u_eval (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (state_ff == S_FEED),
      .entry     (rd_data_ff),
      .rect      (rect_ff),
      .slack     (slack_ff),
      .flags     (ev_flags),
      .cost      (ev_cost),
      .union_box (ev_union)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CapacityReset;
         slack_ff <= SlackReset;
      end else if (csr_write) begin
         if (csr_index == CSR_CAPACITY) begin
            cap_ff <= csr_data[4:0];
         end else begin
            slack_ff <= csr_data;
         end
      end
   end

   logic [CNTW-1:0] cap_sat;
   logic [SW-1:0]   slot_w;
   logic [CNTW-1:0] vc_w;
   logic [CNTW-1:0] next_idx_w;
   logic            accept;
   logic            take_best;

   assign cap_sat    = (CNTW'(cap_ff) > MaxCount) ? MaxCount : CNTW'(cap_ff);
   assign slot_w     = SW'(req_read_slot);
   assign vc_w       = CNTW'(vc_ff);
   assign next_idx_w = CNTW'(idx_ff) + CNTW'(1);
   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign take_best  = (idx_ff == '0) || (ev_cost < least_grow_ff);

   // Sequencer: next state, table writes and result building.
   always_comb begin
      state_in      = state_ff;
      vc_in         = vc_ff;
      rect_in       = rect_ff;
      idx_in        = idx_ff;
      best_idx_in   = best_idx_ff;
      least_grow_in = least_grow_ff;
      best_union_in = best_union_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_box_in    = res_box_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = ev_union;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = slot_w[IW-1:0];
            if (accept) begin
               rect_in     = {req_in_x_min, req_in_y_min, req_in_x_max, req_in_y_max,
                              req_in_source};
               res_slot_in = '0;
               res_box_in  = '0;
               idx_in      = '0;
               state_in    = S_EMIT;
               case (req_cmd)
                  CMD_CLEAR: begin
                     vc_in         = '0;
                     res_status_in = ST_CLEARED;
                  end
                  CMD_READ: begin
                     if (CNTW'(req_read_slot) < vc_w) begin
                        res_slot_in = slot_w[IW-1:0];
                        state_in    = S_RDWAIT;
                     end else begin
                        res_status_in = ST_READ_OOR;
                     end
                  end
                  CMD_ADD: begin
                     if (cap_sat == '0 || req_in_x_min > req_in_x_max ||
                         req_in_y_min > req_in_y_max) begin
                        res_status_in = ST_IGNORED;
                     end else if (vc_ff == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        wr_data       = rect_in;
                        vc_in         = VW'(1);
                        res_status_in = ST_APPENDED;
                        res_box_in    = rect_in;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     res_status_in = ST_IGNORED;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            res_status_in = ST_READ_OK;
            res_box_in    = rd_data_ff;
            state_in      = S_EMIT;
         end
         S_FETCH: begin
            state_in = S_FEED;
         end
         S_FEED: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (ev_flags.valid && ev_flags.merge) begin
               wr_en         = 1'b1;
               wr_addr       = idx_ff;
               wr_data       = ev_union;
               res_status_in = ST_MERGED;
               res_slot_in   = idx_ff;
               res_box_in    = ev_union;
               state_in      = S_EMIT;
            end else begin
               if (take_best) begin
                  best_idx_in   = idx_ff;
                  least_grow_in = ev_cost;
                  best_union_in = ev_union;
               end
               if (next_idx_w < vc_w) begin
                  idx_in   = next_idx_w[IW-1:0];
                  state_in = S_FETCH;
               end else if (vc_w < cap_sat) begin
                  wr_en         = 1'b1;
                  wr_addr       = vc_ff[IW-1:0];
                  wr_data       = rect_ff;
                  vc_in         = vc_ff + VW'(1);
                  res_status_in = ST_APPENDED;
                  res_slot_in   = vc_ff[IW-1:0];
                  res_box_in    = rect_ff;
                  state_in      = S_EMIT;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = best_idx_in;
                  wr_data       = best_union_in;
                  res_status_in = ST_FORCED;
                  res_slot_in   = best_idx_in;
                  res_box_in    = best_union_in;
                  state_in      = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         vc_ff    <= vc_in;
      end
      rect_ff       <= rect_in;
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      least_grow_ff <= least_grow_in;
      best_union_ff <= best_union_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_box_ff    <= res_box_in;
   end

   // Output register; it is loaded when a result is ready and the slot is free.
   logic [SW-1:0]   res_slot_w;
   logic            load_rsp;

   assign res_slot_w = SW'(res_slot_ff);
   assign load_rsp   = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_w[3:0];
         rsp_box_ff    <= res_box_ff;
         rsp_total_ff  <= vc_w[4:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_slot    = rsp_slot_ff;
   assign rsp_out_x_min   = rsp_box_ff[EW-1 -: CB];
   assign rsp_out_y_min   = rsp_box_ff[EW-1-CB -: CB];
   assign rsp_out_x_max   = rsp_box_ff[EW-1-2*CB -: CB];
   assign rsp_out_y_max   = rsp_box_ff[EW-1-3*CB -: CB];
   assign rsp_out_source  = rsp_box_ff[15:0];
   assign rsp_entry_total = rsp_total_ff;

endmodule

`default_nettype wire
